// File: src/cgcs_pkg.sv
// Shared types and constants for the class grouping counting sort core.
// No dependencies.
package cgcs_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int MAX_CLASSES = 64;
  localparam int IW = $clog2(MAX_ITEMS);     // item index width
  localparam int CW = $clog2(MAX_CLASSES);   // class index width
  localparam int NW = IW + 1;                // item count width
  localparam int KW = CW + 1;                // class count width

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_RDORD  = 2'd2,
    CMD_RDCLS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_IFULL  = 2'd1,
    ST_CFULL  = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,    // compare one stored label per cycle
    S_SRCHW,   // read result wait; build result
    S_PUSHW,   // write push result into tables
    S_PFX,     // prefix sum, one class per cycle
    S_SCANR,   // read item class
    S_SCANF,   // read fill pointer of that class
    S_SCANW,   // place item into order
    S_RD,      // dispatch on latched command
    S_OUT      // hold result
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic srch_clr;   // zero search index
    logic srch_step;  // compare and advance
    logic push_wr;    // commit push
    logic fin_start;  // sample mode, zero counters
    logic pfx_step;
    logic scan_rd;
    logic scan_fp;
    logic scan_wr;
    logic rd_issue;
    logic res_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic   hit;
    logic   srch_end;
    logic   pfx_end;
    logic   scan_end;
    logic   by_label;
    cmd_t   cmd;
  } sts_t;

endpackage

// File: src/cgcs_ctrl.sv
// Controller state machine for the class grouping counting sort core.
// Depends on cgcs_pkg.
module cgcs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  cgcs_pkg::sts_t  sts,
  output cgcs_pkg::ctl_t  ctl
);

  cgcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      cgcs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.latch    = 1'b1;
          ctl.srch_clr = 1'b1;
          state_next   = cgcs_pkg::S_RD;
        end
      end
      cgcs_pkg::S_RD: begin
        // item latched; dispatch on command
        unique case (sts.cmd)
          cgcs_pkg::CMD_PUSH: state_next = cgcs_pkg::S_SRCH;
          cgcs_pkg::CMD_FINISH: begin
            ctl.fin_start = 1'b1;
            state_next    = cgcs_pkg::S_PFX;
          end
          default: begin
            ctl.rd_issue = 1'b1;
            state_next   = cgcs_pkg::S_SRCHW;
          end
        endcase
      end
      cgcs_pkg::S_SRCH: begin
        ctl.srch_step = 1'b1;
        if (sts.hit || sts.srch_end) begin
          state_next = cgcs_pkg::S_PUSHW;
        end
      end
      cgcs_pkg::S_PUSHW: begin
        ctl.push_wr  = 1'b1;
        ctl.res_load = 1'b1;
        state_next   = cgcs_pkg::S_OUT;
      end
      cgcs_pkg::S_PFX: begin
        if (!sts.by_label) begin
          ctl.res_load = 1'b1;
          state_next   = cgcs_pkg::S_OUT;
        end else if (sts.pfx_end) begin
          state_next = cgcs_pkg::S_SCANR;
        end else begin
          ctl.pfx_step = 1'b1;
        end
      end
      cgcs_pkg::S_SCANR: begin
        if (sts.scan_end) begin
          ctl.res_load = 1'b1;
          state_next   = cgcs_pkg::S_OUT;
        end else begin
          ctl.scan_rd = 1'b1;
          state_next  = cgcs_pkg::S_SCANF;
        end
      end
      cgcs_pkg::S_SCANF: begin
        ctl.scan_fp = 1'b1;
        state_next  = cgcs_pkg::S_SCANW;
      end
      cgcs_pkg::S_SCANW: begin
        ctl.scan_wr = 1'b1;
        state_next  = cgcs_pkg::S_SCANR;
      end
      cgcs_pkg::S_SRCHW: begin
        // read data registered; build result
        ctl.res_load = 1'b1;
        state_next   = cgcs_pkg::S_OUT;
      end
      cgcs_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = cgcs_pkg::S_IDLE;
        end
      end
      default: state_next = cgcs_pkg::S_IDLE;
    endcase
  end

endmodule

// File: src/cgcs_dp.sv
// Datapath for the class grouping counting sort core: label and class tables,
// item class store, grouped order memory, counters. Depends on cgcs_pkg.
module cgcs_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         classification_mode,
  input  logic [1:0]                   command,
  input  logic signed [31:0]           label_value,
  input  logic [cgcs_pkg::IW-1:0]      position,
  input  logic [cgcs_pkg::CW-1:0]      class_index,
  input  cgcs_pkg::ctl_t               ctl,
  output cgcs_pkg::sts_t               sts,
  output logic [1:0]                   status,
  output logic [cgcs_pkg::CW-1:0]      assigned_class,
  output logic                         new_class,
  output logic [cgcs_pkg::IW-1:0]      original_position,
  output logic signed [31:0]           class_label,
  output logic [cgcs_pkg::NW-1:0]      class_start,
  output logic [cgcs_pkg::NW-1:0]      class_size,
  output logic [cgcs_pkg::KW-1:0]      class_total,
  output logic [cgcs_pkg::NW-1:0]      item_total
);

  localparam int IW = cgcs_pkg::IW;
  localparam int CW = cgcs_pkg::CW;
  localparam int NW = cgcs_pkg::NW;
  localparam int KW = cgcs_pkg::KW;

  // memories
  logic [CW-1:0] item_class    [cgcs_pkg::MAX_ITEMS];
  logic [IW-1:0] grouped_order [cgcs_pkg::MAX_ITEMS];
  logic [31:0]   class_labels  [cgcs_pkg::MAX_CLASSES];
  logic [NW-1:0] class_counts  [cgcs_pkg::MAX_CLASSES];
  logic [NW-1:0] class_starts  [cgcs_pkg::MAX_CLASSES];
  logic [NW-1:0] fill_ptr      [cgcs_pkg::MAX_CLASSES];

  // latched item
  cgcs_pkg::cmd_t cmd;
  logic [31:0]    lab;
  logic [IW-1:0]  pos;
  logic [CW-1:0]  cix;

  // control state
  logic [NW-1:0] item_count;
  logic [KW-1:0] class_count;
  logic          grouped_flag;
  logic          by_label;
  logic [KW-1:0] sidx;      // search / prefix index
  logic [KW-1:0] sidx_inc;
  logic          hit;
  logic [NW-1:0] run;
  logic [NW-1:0] scan_i;
  logic [CW-1:0] scan_c;

  // registered read data
  logic [31:0]   lab_q;     // stored label at sidx
  logic [NW-1:0] cnt_q;     // class count at sidx
  logic [31:0]   lab_rd;
  logic [NW-1:0] cnt_rd;
  logic [NW-1:0] start_rd;
  logic [IW-1:0] ord_rd;
  logic [NW-1:0] fp_rd;

  logic [KW-1:0] vis;
  logic          full_items;
  logic          full_classes;
  logic          ord_bad;
  logic          cls_bad;
  logic          srch_cmp;
  logic          srch_adv;

  assign full_items   = item_count == NW'(cgcs_pkg::MAX_ITEMS);
  assign full_classes = class_count == KW'(cgcs_pkg::MAX_CLASSES);
  assign vis          = (grouped_flag && !by_label) ? KW'(1) : class_count;
  assign ord_bad      = !grouped_flag || ({1'b0, pos} >= item_count);
  assign cls_bad      = !grouped_flag || ({1'b0, cix} >= vis);
  assign srch_cmp     = lab_q == lab;
  assign sidx_inc     = sidx + KW'(1);
  assign srch_adv     = ctl.srch_step && !hit && (sidx != class_count) && !srch_cmp;

  assign sts.hit      = hit;
  assign sts.srch_end = sidx == class_count;
  assign sts.pfx_end  = sidx == class_count;
  assign sts.scan_end = scan_i == item_count;
  assign sts.by_label = by_label;
  assign sts.cmd      = cmd;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd <= cgcs_pkg::cmd_t'(command);
      lab <= label_value;
      pos <= position;
      cix <= class_index;
    end
  end

  // label search: one stored label a cycle, stops on hit; also steps the prefix index
  always_ff @(posedge clk) begin
    if (rst) begin
      sidx <= '0;
      hit  <= 1'b0;
    end else if (ctl.srch_clr || ctl.fin_start) begin
      sidx <= '0;
      hit  <= 1'b0;
    end else if (ctl.srch_step && !hit && sidx != class_count) begin
      if (srch_cmp) begin
        hit <= 1'b1;
      end else begin
        sidx <= sidx_inc;
      end
    end else if (ctl.pfx_step) begin
      sidx <= sidx_inc;
    end
  end

  // label and count at the index that sidx moves to
  always_ff @(posedge clk) begin
    if (ctl.srch_clr || ctl.fin_start) begin
      lab_q <= class_labels[CW'(0)];
      cnt_q <= class_counts[CW'(0)];
    end else if (srch_adv || ctl.pfx_step) begin
      lab_q <= class_labels[sidx_inc[CW-1:0]];
      cnt_q <= class_counts[sidx_inc[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count   <= '0;
      class_count  <= '0;
      grouped_flag <= 1'b0;
      by_label     <= 1'b0;
    end else begin
      if (ctl.push_wr && !full_items && (hit || !full_classes)) begin
        item_count   <= item_count + NW'(1);
        grouped_flag <= 1'b0;
        if (!hit) begin
          class_count <= class_count + KW'(1);
        end
      end
      if (ctl.fin_start) begin
        by_label     <= classification_mode;
        grouped_flag <= 1'b1;
      end
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (ctl.push_wr && !full_items && (hit || !full_classes)) begin
      item_class[item_count[IW-1:0]] <= sidx[CW-1:0];
      if (hit) begin
        class_counts[sidx[CW-1:0]] <= cnt_q + NW'(1);
      end else begin
        class_labels[sidx[CW-1:0]] <= lab;
        class_counts[sidx[CW-1:0]] <= NW'(1);
      end
    end
    if (ctl.pfx_step) begin
      class_starts[sidx[CW-1:0]] <= run;
      fill_ptr[sidx[CW-1:0]]     <= run;
    end
    if (ctl.scan_wr) begin
      grouped_order[fp_rd[IW-1:0]] <= IW'(scan_i - NW'(1));
      fill_ptr[scan_c]             <= fp_rd + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_start) begin
      run <= '0;
    end else if (ctl.pfx_step) begin
      run <= run + cnt_q;
    end
  end

  // scan: read item class, then its fill pointer, then place it
  always_ff @(posedge clk) begin
    if (ctl.fin_start) begin
      scan_i <= '0;
    end else if (ctl.scan_rd) begin
      scan_i <= scan_i + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) begin
      scan_c <= item_class[scan_i[IW-1:0]];
    end
    if (ctl.scan_fp) begin
      fp_rd <= fill_ptr[scan_c];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      ord_rd   <= grouped_order[pos];
      lab_rd   <= class_labels[cix];
      cnt_rd   <= class_counts[cix];
      start_rd <= class_starts[cix];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      status            <= cgcs_pkg::ST_OK;
      assigned_class    <= '0;
      new_class         <= 1'b0;
      original_position <= '0;
      class_label       <= '0;
      class_start       <= '0;
      class_size        <= '0;
      class_total       <= vis;
      item_total        <= item_count;
      unique case (cmd)
        cgcs_pkg::CMD_PUSH: begin
          if (full_items) begin
            status <= cgcs_pkg::ST_IFULL;
          end else if (!hit && full_classes) begin
            status <= cgcs_pkg::ST_CFULL;
          end else begin
            assigned_class <= sidx[CW-1:0];
            new_class      <= !hit;
            item_total     <= item_count + NW'(1);
            class_total    <= hit ? class_count : class_count + KW'(1);
          end
        end
        cgcs_pkg::CMD_FINISH: ;
        cgcs_pkg::CMD_RDORD: begin
          if (ord_bad) begin
            status <= cgcs_pkg::ST_BAD;
          end else begin
            original_position <= by_label ? ord_rd : pos;
          end
        end
        cgcs_pkg::CMD_RDCLS: begin
          if (cls_bad) begin
            status <= cgcs_pkg::ST_BAD;
          end else if (!by_label) begin
            class_size <= item_count;
          end else begin
            class_label <= lab_rd;
            class_start <= start_rd;
            class_size  <= cnt_rd;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/class_grouping_counting_sort_core.sv
// Top level of the class grouping counting sort core.
// Depends on cgcs_pkg, cgcs_ctrl and cgcs_dp.
//
// channel   signals                                          direction
// input     in_valid/in_stall, command, label_value, ...     in
// output    out_valid/out_stall, status, ..., item_total     out
// config    cfg_we, cfg_wdata (classification_mode)          in
//
// One transaction at a time. Push: label search at one stored label a cycle,
// ending early on a hit, then the table write. Finish in grouping mode: prefix
// pass, then an item scan that reads each item's class, then its fill pointer,
// then places it. Finish in regression mode and reads skip the search and scans.
// Reset is synchronous; the result is held while out_stall, and the input
// stalls until it is taken.
module class_grouping_counting_sort_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic signed [31:0]          label_value,
  input  logic [cgcs_pkg::IW-1:0]     position,
  input  logic [cgcs_pkg::CW-1:0]     class_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [cgcs_pkg::CW-1:0]     assigned_class,
  output logic                        new_class,
  output logic [cgcs_pkg::IW-1:0]     original_position,
  output logic signed [31:0]          class_label,
  output logic [cgcs_pkg::NW-1:0]     class_start,
  output logic [cgcs_pkg::NW-1:0]     class_size,
  output logic [cgcs_pkg::KW-1:0]     class_total,
  output logic [cgcs_pkg::NW-1:0]     item_total
);

  logic           classification_mode;
  cgcs_pkg::ctl_t ctl;
  cgcs_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      classification_mode <= 1'b1;
    end else if (cfg_we) begin
      classification_mode <= cfg_wdata;
    end
  end

  cgcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  cgcs_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .classification_mode (classification_mode),
    .command             (command),
    .label_value         (label_value),
    .position            (position),
    .class_index         (class_index),
    .ctl                 (ctl),
    .sts                 (sts),
    .status              (status),
    .assigned_class      (assigned_class),
    .new_class           (new_class),
    .original_position   (original_position),
    .class_label         (class_label),
    .class_start         (class_start),
    .class_size          (class_size),
    .class_total         (class_total),
    .item_total          (item_total)
  );

endmodule

// File: src/cgcs_checker.sv
// Port-level checks for the class grouping counting sort core.
// Depends on cgcs_pkg; bound to class_grouping_counting_sort_core.
module cgcs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [cgcs_pkg::CW-1:0]     assigned_class,
  input logic                        new_class,
  input logic [cgcs_pkg::NW-1:0]     item_total,
  input logic [cgcs_pkg::KW-1:0]     class_total
);

  // a waiting result blocks new transactions
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken with result pending");

  // an accepted transaction closes the input right away
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("input open after accept");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(item_total) && $stable(status))
    else $error("stalled result changed");

  a_new_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_class |->
      {1'b0, assigned_class} == class_total - cgcs_pkg::KW'(1))
    else $error("new class number is not the last class");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> item_total <= cgcs_pkg::NW'(cgcs_pkg::MAX_ITEMS)
      && class_total <= cgcs_pkg::KW'(cgcs_pkg::MAX_CLASSES))
    else $error("totals out of range");

endmodule

bind class_grouping_counting_sort_core cgcs_checker u_cgcs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .assigned_class (assigned_class),
  .new_class      (new_class),
  .item_total     (item_total),
  .class_total    (class_total)
);
